// ----- sv/plq_pkg.sv -----
// ----------------------------------------------------------------------------
// plq_pkg
// Field widths, operation and status codes and the stored entry layout of the
// price level order queue.
// ----------------------------------------------------------------------------
package plq_pkg;

  // field widths
  localparam int ID_W      = 63;
  localparam int QTY_W     = 32;
  localparam int PRICE_W   = 32;
  localparam int POS_W     = 6;
  localparam int CNT_OUT_W = 7;
  localparam int TOT_W     = 40;
  localparam int FUNC_W    = 2;
  localparam int STAT_W    = 2;

  // packed stream widths
  localparam int S_TDATA_W = 96;
  localparam int M_TDATA_W = 184;
  localparam int M_PAD_W   = M_TDATA_W - (ID_W + QTY_W + 1 + PRICE_W + POS_W
                                          + CNT_OUT_W + TOT_W);

  // most records one dump reports
  localparam int MAX_RESULTS = 32;

  // operation codes
  localparam logic [FUNC_W-1:0] FUNC_ADD    = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_CANCEL = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_DUMP   = 2'd2;

  // status codes
  localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL      = 2'd1;
  localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd2;
  localparam logic [STAT_W-1:0] STAT_EMPTY     = 2'd3;

  // one stored order, id in the low bits
  typedef struct packed {
    logic             buy;
    logic [QTY_W-1:0] qty;
    logic [ID_W-1:0]  id;
  } entry_t;

endpackage

// ----- sv/price_level_order_queue.sv -----
// ----------------------------------------------------------------------------
// price_level_order_queue
// One price level of an order book: an arrival-ordered queue of orders kept
// in a single-port-write / single-port-read memory, walked by a sequencer.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake           payload
//  s_*       in   s_tvalid/s_tready   s_tdata: order_id, quantity, is_buy
//                                     s_tuser: func
//  m_*       out  m_tvalid/m_tready   m_tdata: record, price, position,
//                                     count, total; m_tuser: status; m_tlast
//  cfg_*     in   cfg_valid/cfg_ready cfg_data: level_price
//
//  Add, unknown codes and a cancel on an empty level answer directly from the
//  decode state. A cancel searches for the id, then closes the gap with the
//  one-entry-per-cycle shift of the later entries; the memory read port is
//  shared by the id search and by the shift. A dump reads the stored entries
//  one at a time, up to the record limit.
//  Reset clears count, total, price and control; the entry memory is not
//  cleared. A stalled m_tready holds the sequencer when it has a word to emit;
//  one result word waits in the output register while the next word is accepted.
// ----------------------------------------------------------------------------
module price_level_order_queue #(
  parameter int QUEUE_DEPTH = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  // order_id [62:0], quantity [94:63], is_buy [95]
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [plq_pkg::S_TDATA_W-1:0]  s_tdata,
  // func [1:0]
  input  logic [plq_pkg::FUNC_W-1:0]     s_tuser,
  // rec_order_id [62:0], rec_quantity [94:63], rec_is_buy [95],
  // rec_price [127:96], queue_position [133:128], order_count [140:134],
  // total_quantity [180:141], zero [183:181]
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [plq_pkg::M_TDATA_W-1:0]  m_tdata,
  // status [1:0]
  output logic [plq_pkg::STAT_W-1:0]     m_tuser,
  output logic                           m_tlast,
  // level_price
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [plq_pkg::PRICE_W-1:0]    cfg_data
);
  import plq_pkg::*;

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SEARCH,
    ST_SHIFT,
    ST_DUMP
  } state_t;

  state_t             state;
  logic [FUNC_W-1:0]  op_func;
  entry_t             op_entry;
  logic [CW-1:0]      count;
  logic [TOT_W-1:0]   total;
  logic [PRICE_W-1:0] price;

  // read pipeline
  logic [CW-1:0]      rd_idx;
  logic [AW-1:0]      cmp_idx;
  logic               rd_vld;

  // dump look-ahead record
  logic               hold_vld;
  entry_t             hold;
  logic [POS_W-1:0]   hold_pos;

  // output register
  logic [STAT_W-1:0]    out_status;
  entry_t               out_rec;
  logic [PRICE_W-1:0]   out_price;
  logic [POS_W-1:0]     out_pos;
  logic [CNT_OUT_W-1:0] out_count;
  logic [TOT_W-1:0]     out_total;
  logic                 out_last;

  // memory
  entry_t             mem [QUEUE_DEPTH];
  entry_t             rd_data;
  logic               rd_en;
  logic [AW-1:0]      rd_addr;
  logic               we;
  logic [AW-1:0]      waddr;
  entry_t             wdata;

  // sequencer decisions
  logic               can_emit;
  logic               more;
  logic               live;
  logic               match;
  logic               emit;
  logic               done;
  logic               found;
  logic               consume;
  logic               keep;
  logic [STAT_W-1:0]  e_status;
  entry_t             e_rec;
  logic [PRICE_W-1:0] e_price;
  logic [POS_W-1:0]   e_pos;
  logic               e_last;
  logic [CW-1:0]      e_count;
  logic [TOT_W-1:0]   e_total;
  logic [TOT_W:0]     add_sum;
  logic [TOT_W-1:0]   cxl_qty;

  assign s_tready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;

  assign m_tdata = {{M_PAD_W{1'b0}}, out_total, out_count, out_pos, out_price,
                    out_rec.buy, out_rec.qty, out_rec.id};
  assign m_tuser = out_status;
  assign m_tlast = out_last;

  assign can_emit = !m_tvalid || m_tready;
  assign more     = (rd_idx < count);
  assign live     = rd_vld && (rd_data.qty != '0);
  assign match    = rd_vld && (rd_data.id == op_entry.id);
  assign rd_addr  = rd_idx[AW-1:0];
  assign add_sum  = {1'b0, total} + (TOT_W+1)'(op_entry.qty);
  assign cxl_qty  = TOT_W'(op_entry.qty);

  // sequencer step: memory access and result word for this cycle
  always_comb begin
    rd_en    = 1'b0;
    we       = 1'b0;
    waddr    = count[AW-1:0];
    wdata    = op_entry;
    emit     = 1'b0;
    done     = 1'b0;
    found    = 1'b0;
    consume  = 1'b0;
    keep     = 1'b0;
    e_status = STAT_OK;
    e_rec    = '0;
    e_price  = '0;
    e_pos    = '0;
    e_last   = 1'b1;
    e_count  = count;
    e_total  = total;
    case (state)
      ST_DECODE: begin
        case (op_func)
          FUNC_ADD: begin
            emit = can_emit;
            done = can_emit;
            if (count >= CW'(QUEUE_DEPTH)) begin
              e_status = STAT_FULL;
            end else begin
              we      = can_emit;
              e_count = count + CW'(1);
              e_total = add_sum[TOT_W] ? {TOT_W{1'b1}} : add_sum[TOT_W-1:0];
            end
          end
          FUNC_CANCEL: begin
            if (count == '0) begin
              emit     = can_emit;
              done     = can_emit;
              e_status = STAT_EMPTY;
            end
          end
          FUNC_DUMP: begin
            // walk starts next cycle
          end
          default: begin
            emit = can_emit;
            done = can_emit;
          end
        endcase
      end
      ST_SEARCH: begin
        if (match) begin
          found = 1'b1;
        end else if (!rd_vld && !more) begin
          emit     = can_emit;
          done     = can_emit;
          e_status = STAT_NOT_FOUND;
        end else begin
          rd_en = more;
        end
      end
      ST_SHIFT: begin
        // move entry k+1 down to k
        if (rd_vld) begin
          we    = 1'b1;
          waddr = cmp_idx - AW'(1);
          wdata = rd_data;
        end
        rd_en = more;
        if (!rd_vld && !more) begin
          emit    = can_emit;
          done    = can_emit;
          e_count = count - CW'(1);
          e_total = (cxl_qty >= total) ? '0 : total - cxl_qty;
        end
      end
      ST_DUMP: begin
        e_price = price;
        if (hold_vld && hold_pos == POS_W'(MAX_RESULTS - 1)) begin
          // record limit reached
          emit  = can_emit;
          done  = can_emit;
          e_rec = hold;
          e_pos = hold_pos;
        end else if (rd_vld) begin
          if (live && hold_vld) begin
            consume = can_emit;
            emit    = can_emit;
            e_rec   = hold;
            e_pos   = hold_pos;
            e_last  = 1'b0;
          end else begin
            consume = 1'b1;
          end
          keep  = !consume;
          rd_en = consume && more;
        end else if (more) begin
          rd_en = 1'b1;
        end else begin
          // walk finished: flush held record or report empty
          emit = can_emit;
          done = can_emit;
          if (hold_vld) begin
            e_rec = hold;
            e_pos = hold_pos;
          end else begin
            e_status = STAT_EMPTY;
            e_price  = '0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // entry memory, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      count    <= '0;
      total    <= '0;
      price    <= '0;
      rd_vld   <= 1'b0;
      rd_idx   <= '0;
      hold_vld <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        price <= cfg_data;
      end

      // output word
      if (emit) begin
        m_tvalid   <= 1'b1;
        out_status <= e_status;
        out_rec    <= e_rec;
        out_price  <= e_price;
        out_pos    <= e_pos;
        out_count  <= CNT_OUT_W'(e_count);
        out_total  <= e_total;
        out_last   <= e_last;
        count      <= e_count;
        total      <= e_total;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      // read pipeline
      if (rd_en) begin
        rd_idx  <= rd_idx + CW'(1);
        cmp_idx <= rd_idx[AW-1:0];
      end
      rd_vld <= rd_en || (rd_vld && keep);

      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            op_func      <= s_tuser;
            op_entry.id  <= s_tdata[ID_W-1:0];
            op_entry.qty <= s_tdata[ID_W+QTY_W-1:ID_W];
            op_entry.buy <= s_tdata[ID_W+QTY_W];
            state        <= ST_DECODE;
          end
        end
        ST_DECODE: begin
          rd_idx   <= '0;
          hold_vld <= 1'b0;
          if (done) begin
            state <= ST_IDLE;
          end else if (op_func == FUNC_CANCEL && count != '0) begin
            state <= ST_SEARCH;
          end else if (op_func == FUNC_DUMP) begin
            state <= ST_DUMP;
          end
        end
        ST_SEARCH: begin
          if (found) begin
            state  <= ST_SHIFT;
            rd_idx <= CW'(cmp_idx) + CW'(1);
          end else if (done) begin
            state <= ST_IDLE;
          end
        end
        ST_SHIFT: begin
          if (done) begin
            state <= ST_IDLE;
          end
        end
        ST_DUMP: begin
          if (consume && live) begin
            hold     <= rd_data;
            hold_vld <= 1'b1;
            hold_pos <= hold_vld ? hold_pos + POS_W'(1) : '0;
          end
          if (done) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(QUEUE_DEPTH))
    else $error("stored count above queue depth");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    emit |-> (!m_tvalid || m_tready))
    else $error("result word overwrites one not yet taken");

  a_shift_ports: assert property (@(posedge clk) disable iff (rst)
    (we && rd_en) |-> (waddr != rd_addr))
    else $error("shift writes the entry being read");

  a_dump_pos: assert property (@(posedge clk) disable iff (rst)
    (emit && state == ST_DUMP && e_status == STAT_OK) |=> (m_tvalid && out_rec.qty != '0))
    else $error("dump reported a zero quantity record");

endmodule
